FILE: src/plstore_pkg.sv
// Shared types and constants for the positional list store.
package plstore_pkg;

   localparam int DATA_W = 32;
   localparam int POS_W = 7;
   localparam int CAP_W = 7;
   localparam int DEFAULT_DEPTH = 64;
   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
   localparam logic signed [DATA_W-1:0] ERR_DATA = -32'sd1;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2
   } cell_op_type;

   // broadcast from the control logic to every cell
   typedef struct packed {
      cell_op_type               op;
      logic [POS_W-1:0]          slot;   // 0-based target index
      logic signed [DATA_W-1:0]  value;
   } cell_ctrl_type;

endpackage

FILE: src/plstore_cell.sv
// One storage cell of the list: holds a single entry and shifts with its neighbors.
module plstore_cell #(
   parameter int IDX = 0
) (
   input  logic                              clock,
   input  plstore_pkg::cell_ctrl_type        ctrl,
   input  logic signed [plstore_pkg::DATA_W-1:0] prev_data,
   input  logic signed [plstore_pkg::DATA_W-1:0] next_data,
   input  logic signed [plstore_pkg::DATA_W-1:0] rd_in,
   output logic signed [plstore_pkg::DATA_W-1:0] entry,
   output logic signed [plstore_pkg::DATA_W-1:0] rd_out
);
   import plstore_pkg::*;

   localparam int IDX_W = (IDX < 2) ? 1 : $clog2(IDX + 1);
   localparam int CW = (IDX_W > POS_W) ? IDX_W : POS_W;
   localparam logic [CW-1:0] MY_IDX = CW'(IDX);

   logic signed [DATA_W-1:0] entry_ff, entry_in;
   logic [CW-1:0]            slot_ext;
   logic                     at_slot, above_slot;

   assign slot_ext   = CW'(ctrl.slot);
   assign at_slot    = (MY_IDX == slot_ext);
   assign above_slot = (MY_IDX > slot_ext);

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         OP_INSERT: begin
            if (at_slot) begin
               entry_in = ctrl.value;
            end else if (above_slot) begin
               entry_in = prev_data;
            end
         end
         OP_REMOVE: begin
            if (at_slot || above_slot) begin
               entry_in = next_data;
            end
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry  = entry_ff;
   // read path ripples along the row; only the addressed cell contributes
   assign rd_out = rd_in | (at_slot ? entry_ff : '0);

endmodule

FILE: src/positional_list_store.sv
// Top level of the positional list store: control, length and capacity tracking, cell row.
//
// Ordered list of signed 32-bit entries addressed by 1-based position. Each item is
// insert, remove or read; one item is taken per clock and its result appears in the
// output register on the next cycle, so the sustained rate is one item per cycle as long
// as results are taken. Insert and remove move every affected entry at once through a
// row of DEPTH cells, each loading from its left or right neighbor; a read selects its
// entry through an OR chain running along the same row. A position out of range, or an
// insert into a full list, returns ok=0 and read_data=-1 with the list untouched. The
// capacity in force is the smaller of the capacity register and DEPTH. No clearing pass
// is needed after reset: the length starts at zero and only written entries are read.
module positional_list_store #(
   parameter int DEPTH = plstore_pkg::DEFAULT_DEPTH
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic [1:0]                                req_command,
   input  logic [plstore_pkg::POS_W-1:0]             req_position,
   input  logic signed [plstore_pkg::DATA_W-1:0]     req_value,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic                                      rsp_ok,
   output logic signed [plstore_pkg::DATA_W-1:0]     rsp_read_data,
   output logic [plstore_pkg::CAP_W-1:0]             rsp_length,
   output logic                                      rsp_full_res,
   input  logic                                      csr_wr_en,
   input  logic [plstore_pkg::CAP_W-1:0]             csr_wr_data
);
   import plstore_pkg::*;

   localparam int CAP_MAX = (1 << CAP_W) - 1;
   localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'((DEPTH < CAP_MAX) ? DEPTH : CAP_MAX);

   logic [CAP_W-1:0]          capacity_ff, capacity_in;
   logic [CAP_W-1:0]          count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_ok_ff, rsp_ok_in;
   logic signed [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [CAP_W-1:0]          rsp_length_ff, rsp_length_in;
   logic                      rsp_full_ff, rsp_full_in;

   logic [CAP_W-1:0]          cap_eff;
   logic                      accept;
   logic                      pos_nonzero, pos_in_list, pos_insertable;
   cmd_type                   cmd;
   cell_ctrl_type             ctrl;

   logic signed [DATA_W-1:0]  entry_w [DEPTH];
   logic signed [DATA_W-1:0]  rd_chain [DEPTH+1];

   assign cap_eff   = (capacity_ff < CAP_LIMIT) ? capacity_ff : CAP_LIMIT;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign cmd       = cmd_type'(req_command);

   assign pos_nonzero    = (req_position != '0);
   assign pos_in_list    = pos_nonzero && (req_position <= count_ff);
   assign pos_insertable = pos_nonzero
                           && ({1'b0, req_position} <= ({1'b0, count_ff} + 8'd1))
                           && (count_ff < cap_eff);

   always_comb begin
      ctrl.op     = OP_HOLD;
      ctrl.slot   = req_position - POS_W'(1);
      ctrl.value  = req_value;
      count_in    = count_ff;
      rsp_ok_in   = 1'b0;
      rsp_data_in = ERR_DATA;
      case (cmd)
         CMD_INSERT: begin
            if (pos_insertable) begin
               ctrl.op     = accept ? OP_INSERT : OP_HOLD;
               count_in    = count_ff + CAP_W'(1);
               rsp_ok_in   = 1'b1;
               rsp_data_in = '0;
            end
         end
         CMD_REMOVE: begin
            if (pos_in_list) begin
               ctrl.op     = accept ? OP_REMOVE : OP_HOLD;
               count_in    = count_ff - CAP_W'(1);
               rsp_ok_in   = 1'b1;
               rsp_data_in = '0;
            end
         end
         CMD_READ: begin
            if (pos_in_list) begin
               rsp_ok_in   = 1'b1;
               rsp_data_in = rd_chain[0];
            end
         end
         default: begin
            rsp_ok_in   = 1'b0;
            rsp_data_in = ERR_DATA;
         end
      endcase
      rsp_length_in = count_in;
      rsp_full_in   = (count_in >= cap_eff);
      rsp_valid_in  = accept || (rsp_valid_ff && !rsp_ready);
   end

   assign capacity_in = csr_wr_en ? csr_wr_data : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ok_ff     <= rsp_ok_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_length_ff <= rsp_length_in;
         rsp_full_ff   <= rsp_full_in;
      end
   end

   assign rd_chain[DEPTH] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] prev_d, next_d;
      if (i == 0) begin : g_first
         assign prev_d = '0;
      end else begin : g_mid_prev
         assign prev_d = entry_w[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign next_d = '0;
      end else begin : g_mid_next
         assign next_d = entry_w[i+1];
      end
      plstore_cell #(
         .IDX(i)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .prev_data (prev_d),
         .next_data (next_d),
         .rd_in     (rd_chain[i+1]),
         .entry     (entry_w[i]),
         .rd_out    (rd_chain[i])
      );
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_length    = rsp_length_ff;
   assign rsp_full_res  = rsp_full_ff;

endmodule

FILE: tb/positional_list_store_checker.sv
`timescale 1ns / 100ps
// Checker for the positional list store: watches both channels, models the list, compares results.
module positional_list_store_checker #(
   parameter int DEPTH = plstore_pkg::DEFAULT_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic [1:0]                            req_command,
   input  logic [plstore_pkg::POS_W-1:0]         req_position,
   input  logic signed [plstore_pkg::DATA_W-1:0] req_value,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic                                  rsp_ok,
   input  logic signed [plstore_pkg::DATA_W-1:0] rsp_read_data,
   input  logic [plstore_pkg::CAP_W-1:0]         rsp_length,
   input  logic                                  rsp_full_res,
   input  logic                                  csr_wr_en,
   input  logic [plstore_pkg::CAP_W-1:0]         csr_wr_data,
   output int                                    pending,
   output int                                    fail_count
);
   import plstore_pkg::*;

   typedef struct {
      logic                     ok;
      logic signed [DATA_W-1:0] read_data;
      logic [CAP_W-1:0]         length;
      logic                     full;
   } list_result_type;

   logic signed [DATA_W-1:0] list_mem [DEPTH];
   int                       list_len = 0;
   logic [CAP_W-1:0]         capacity = CAP_RESET;
   list_result_type          results_owed [$];

   initial begin
      pending = 0;
      fail_count = 0;
   end

   // one command against the list copy; returns the result the block owes for it
   function automatic list_result_type apply_list_command(input logic [1:0] cmd,
         input logic [POS_W-1:0] pos, input logic signed [DATA_W-1:0] val);
      list_result_type r;
      int p;
      int limit;
      p = pos;
      limit = (capacity < DEPTH) ? capacity : DEPTH;
      r.ok = 1'b0;
      r.read_data = ERR_DATA;
      case (cmd)
         CMD_INSERT: begin
            if (p >= 1 && p <= list_len + 1 && list_len < limit) begin
               for (int i = list_len; i >= p; i--)
                  list_mem[i] = list_mem[i-1];
               list_mem[p-1] = val;
               list_len++;
               r.ok = 1'b1;
               r.read_data = '0;
            end
         end
         CMD_REMOVE: begin
            if (p >= 1 && p <= list_len) begin
               for (int i = p; i < list_len; i++)
                  list_mem[i-1] = list_mem[i];
               list_len--;
               r.ok = 1'b1;
               r.read_data = '0;
            end
         end
         CMD_READ: begin
            if (p >= 1 && p <= list_len) begin
               r.ok = 1'b1;
               r.read_data = list_mem[p-1];
            end
         end
         default: ;  // unused code: error, list untouched
      endcase
      r.length = list_len[CAP_W-1:0];
      r.full = (list_len >= limit);
      return r;
   endfunction

   function automatic void compare_field(input string name, input logic signed [63:0] want_v,
         input logic signed [63:0] got_v);
      if (want_v !== got_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         results_owed.delete();
         list_len = 0;
         capacity = CAP_RESET;
      end else begin
         if (csr_wr_en)
            capacity = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (results_owed.size() == 0) begin
               $error("result item with nothing pending");
               fail_count++;
            end else begin
               want = results_owed.pop_front();
               compare_field("ok", want.ok, rsp_ok);
               compare_field("read_data", want.read_data, rsp_read_data);
               compare_field("length", want.length, rsp_length);
               compare_field("full_res", want.full, rsp_full_res);
            end
         end
         if (req_valid && req_ready)
            results_owed.push_back(apply_list_command(req_command, req_position, req_value));
      end
      pending <= results_owed.size();
   end

endmodule

FILE: tb/positional_list_store_test.sv
`timescale 1ns / 100ps
// Testbench top for the positional list store: stimulus, handshake pacing and verdict.
module positional_list_store_test;
   import plstore_pkg::*;

   localparam int STORE_DEPTH = DEFAULT_DEPTH;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_ITEMS = 150;
   localparam int NUM_PHASES = 12;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [1:0]               req_command = CMD_READ;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_ok;
   logic signed [DATA_W-1:0] rsp_read_data;
   logic [CAP_W-1:0]         rsp_length;
   logic                     rsp_full_res;
   logic                     csr_wr_en = 1'b0;
   logic [CAP_W-1:0]         csr_wr_data = '0;

   int pending;
   int fail_count;
   int cycle_count = 0;

   // pacing
   int send_idle_pct = 6;
   int recv_idle_pct = 74;
   logic hold_arm = 1'b0;
   logic hold_seen = 1'b0;
   int hold_left = 0;

   // stimulus-side length guess, used only to shape well-formed positions
   int fill = 0;
   int cap_now = CAP_RESET;
   int items_sent = 0;

   positional_list_store #(.DEPTH(STORE_DEPTH)) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_position  (req_position),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_ok        (rsp_ok),
      .rsp_read_data (rsp_read_data),
      .rsp_length    (rsp_length),
      .rsp_full_res  (rsp_full_res),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   positional_list_store_checker #(.DEPTH(STORE_DEPTH)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_position  (req_position),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_ok        (rsp_ok),
      .rsp_read_data (rsp_read_data),
      .rsp_length    (rsp_length),
      .rsp_full_res  (rsp_full_res),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .pending       (pending),
      .fail_count    (fail_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("positional_list_store_test NOT OK");
         $finish;
      end
   end

   // result side: random stalls, plus a long hold-off whenever hold_arm toggles
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_arm != hold_seen) begin
         hold_seen <= hold_arm;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic int list_limit();
      return (cap_now < STORE_DEPTH) ? cap_now : STORE_DEPTH;
   endfunction

   task automatic send_item(input logic [1:0] cmd, input logic [POS_W-1:0] pos,
         input logic signed [DATA_W-1:0] val);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_position <= pos;
      req_value <= val;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (cmd == CMD_INSERT && pos >= 1 && pos <= fill + 1 && fill < list_limit())
         fill++;
      else if (cmd == CMD_REMOVE && pos >= 1 && pos <= fill)
         fill--;
      items_sent++;
      // idle pattern: sender light / receiver heavy, then swapped, then none
      if (items_sent == 620) begin
         send_idle_pct = 74;
         recv_idle_pct <= 6;
      end else if (items_sent == 1240) begin
         send_idle_pct = 0;
         recv_idle_pct <= 0;
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= cap;
      cap_now = cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_random_item(input int ins_pct);
      logic [1:0] cmd;
      int top_pos;
      int sel;
      int pos;
      sel = $urandom_range(99);
      if (sel < 4)
         cmd = CMD_UNUSED;
      else if (sel < 4 + ins_pct)
         cmd = CMD_INSERT;
      else if ($urandom_range(1) == 0)
         cmd = CMD_REMOVE;
      else
         cmd = CMD_READ;
      top_pos = (cmd == CMD_INSERT) ? fill + 1 : fill;
      if (top_pos < 1)
         top_pos = 1;
      sel = $urandom_range(99);
      if (sel < 8)
         pos = $urandom_range(127);
      else if (sel < 14)
         pos = 1;
      else if (sel < 20)
         pos = top_pos;
      else
         pos = $urandom_range(top_pos, 1);
      send_item(cmd, pos[POS_W-1:0], $urandom);
   endtask

   initial begin
      int phase_cap [NUM_PHASES];
      int phase_ins [NUM_PHASES];
      phase_cap = '{127, 64, 10, 0, 1, 2, 64, 33, 0, 64, 0, 5};
      phase_ins = '{75, 50, 30, 40, 50, 50, 35, 55, 50, 50, 50, 50};
      phase_cap[8] = $urandom_range(64, 1);
      phase_cap[10] = $urandom_range(127);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty list, bad positions, extreme values, reads at and past the end
      send_item(CMD_READ, 1, 0);
      send_item(CMD_REMOVE, 1, 0);
      send_item(CMD_INSERT, 0, 32'sd5);
      send_item(CMD_INSERT, 2, 32'sd6);
      send_item(CMD_INSERT, 1, 32'sh7FFFFFFF);
      send_item(CMD_INSERT, 1, 32'sh80000000);
      send_item(CMD_INSERT, 3, -32'sd1);
      send_item(CMD_INSERT, 2, 32'sd0);
      send_item(CMD_READ, 1, 0);
      send_item(CMD_READ, 2, 0);
      send_item(CMD_READ, 3, 0);
      send_item(CMD_READ, 4, 0);
      send_item(CMD_READ, 5, 0);
      send_item(CMD_READ, 0, 0);
      send_item(CMD_READ, 127, 0);
      send_item(CMD_INSERT, 127, 32'sd7);
      send_item(CMD_REMOVE, 4, 0);
      send_item(CMD_REMOVE, 1, 0);
      send_item(CMD_REMOVE, 0, 0);
      send_item(CMD_REMOVE, 3, 0);
      send_item(CMD_UNUSED, 1, 0);
      send_item(CMD_UNUSED, 127, -32'sd1);
      send_item(CMD_READ, 2, 0);
      send_item(CMD_READ, 1, 0);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_capacity(phase_cap[ph][CAP_W-1:0]);
         // long result hold-off while items keep coming, so the input backs up
         if (ph == 1 || ph == 10)
            hold_arm <= ~hold_arm;
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_random_item(phase_ins[ph]);
      end

      wait_drained();
      repeat (5) @(posedge clock);
      if (pending != 0)
         $error("%0d result items never arrived", pending);
      if (fail_count == 0 && pending == 0)
         $display("positional_list_store_test OK");
      else
         $display("positional_list_store_test NOT OK");
      $finish;
   end

endmodule

FILE: files.f
src/plstore_pkg.sv
src/plstore_cell.sv
src/positional_list_store.sv
tb/positional_list_store_checker.sv
tb/positional_list_store_test.sv
